// File: rtl/core/primary_chromaticity_shift_assert.svh
// ----------------------------------------------------------------------------
// primary chromaticity shift assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PRIMARY_CHROMATICITY_SHIFT_ASSERT_SVH
`define PRIMARY_CHROMATICITY_SHIFT_ASSERT_SVH

// clocked property, ignored while reset is held
`define PCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked property that also holds during reset
`define PCS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// constants, types and state codes for the primary chromaticity shift block
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int FRAC_BITS    = 30;
    localparam int BISECT_STEPS = 40;
    localparam int UV_INT_BITS  = 10;

    // quotient magnitude bits, signed quotient width
    localparam int QB  = FRAC_BITS + UV_INT_BITS;
    localparam int QW  = QB + 2;
    // u'v' point, white-to-primary vector, divider operand widths
    localparam int UW  = FRAC_BITS + 18;
    localparam int VW  = FRAC_BITS + 13;
    localparam int DW  = FRAC_BITS + 22;
    localparam int RW  = DW + QB;
    localparam int CW  = $clog2(QB + 1);
    // signed gain, product and accumulator widths
    localparam int GW  = 20;
    localparam int PW  = GW + VW;
    localparam int AW  = PW + 1;
    localparam int BCW = $clog2(BISECT_STEPS + 1);

    localparam longint Y_MIN = (longint'(1) << FRAC_BITS) / 1000000;

    localparam logic signed [DW-1:0] FX_THREE = DW'(3) << FRAC_BITS;
    localparam logic signed [DW-1:0] FX_FOUR  = DW'(4) << FRAC_BITS;
    localparam logic signed [QW-1:0] UV_LIM   = QW'(1) << QB;
    localparam logic signed [QW-1:0] Y_MIN_Q  = QW'(Y_MIN);
    localparam logic signed [GW-1:0] GAIN_ONE = GW'(65536);

    localparam logic CFG_WHITE_X = 1'b0;
    localparam logic CFG_WHITE_Y = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WU,
        S_WV,
        S_PU,
        S_PV,
        S_VEC,
        S_MUL,
        S_HX,
        S_HY,
        S_HCHK,
        S_BMID,
        S_BX,
        S_BY,
        S_BCHK,
        S_FX,
        S_FY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] num;
        logic signed [DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic                 zero;
        logic signed [QW-1:0] quo;
    } t_div_rsp;

endpackage

// File: rtl/core/pcs_div.sv
// ----------------------------------------------------------------------------
// pcs_div
// serial fixed-point divider: num * 2^F / den, truncated, saturated
// ----------------------------------------------------------------------------
module pcs_div
    import pcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        r_dsh;
    logic [QB-1:0]        r_quo;
    logic                 r_neg;
    logic                 r_done;
    logic                 r_zero;
    logic signed [QW-1:0] r_q;

    logic [DW-1:0]        nmag;
    logic [DW-1:0]        dmag;
    logic                 ovf;
    logic                 fit;
    logic [RW-1:0]        rem_sub;
    logic [QB-1:0]        quo_n;
    logic signed [QW-1:0] quo_s;

    always_comb begin
        nmag    = i_req.num[DW-1] ? DW'(-i_req.num) : DW'(i_req.num);
        dmag    = i_req.den[DW-1] ? DW'(-i_req.den) : DW'(i_req.den);
        // integer part of the quotient reaches 2^UV_INT_BITS
        ovf     = {{UV_INT_BITS{1'b0}}, nmag} >= {dmag, {UV_INT_BITS{1'b0}}};
        fit     = r_rem >= r_dsh;
        rem_sub = r_rem - r_dsh;
        quo_n   = {r_quo[QB-2:0], fit};
        quo_s   = $signed({2'b00, quo_n});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (fit) begin
                    r_rem <= rem_sub;
                end
                r_quo <= quo_n;
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= r_neg ? -quo_s : quo_s;
                end
            end else if (i_req.start) begin
                r_zero <= (i_req.den == '0);
                r_neg  <= i_req.num[DW-1] != i_req.den[DW-1];
                if (i_req.den == '0) begin
                    r_done <= 1'b1;
                    if (i_req.num == '0) begin
                        r_q <= '0;
                    end else begin
                        r_q <= i_req.num[DW-1] ? -UV_LIM : UV_LIM;
                    end
                end else if (ovf) begin
                    r_done <= 1'b1;
                    r_q    <= (i_req.num[DW-1] != i_req.den[DW-1]) ? -UV_LIM : UV_LIM;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(QB);
                    r_quo  <= '0;
                    r_rem  <= RW'(nmag) << FRAC_BITS;
                    r_dsh  <= RW'(dmag) << (QB - 1);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = r_zero;
    assign o_rsp.quo  = r_q;

endmodule

// File: rtl/core/primary_chromaticity_shift.sv
// ----------------------------------------------------------------------------
// primary_chromaticity_shift
// moves one primary chromaticity in u'v' space around the configured white
// ----------------------------------------------------------------------------
// One request is worked at a time; o_ready is high only while the block is
// idle, and a finished result waits in the output register while the next
// request is taken. All divisions go through one serial divider that works
// one quotient bit a cycle; a division by zero or one whose quotient
// saturates is answered without the serial steps. A request without
// pull-in needs six divisions, the multiply steps and the control states. A
// pulled-in target adds 2*(BISECT_STEPS+1) divisions. A primary equal to the
// white point in u'v' finishes after four divisions.
module primary_chromaticity_shift
    import pcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_primary_x,
    input  logic signed [31:0] i_primary_y,
    input  logic [18:0] i_sat_gain,
    input  logic [18:0] i_hue_gain,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_moved_x,
    output logic signed [31:0] o_moved_y,
    output logic        o_pulled_in
);

    t_state r_state, n_state;

    logic signed [31:0]    r_wx, r_wy;
    logic signed [31:0]    r_px, r_py;
    logic [18:0]           r_sat, r_hue;
    logic signed [QW-1:0]  r_wu, r_wv, r_pu, r_pv;
    logic signed [VW-1:0]  r_vu, r_vv;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic [2:0]            r_mcnt;
    logic signed [UW-1:0]  r_cu, r_cv;
    logic signed [UW-1:0]  r_lo_u, r_lo_v, r_hi_u, r_hi_v;
    logic signed [QW-1:0]  r_x, r_y;
    logic                  r_zero;
    logic [BCW-1:0]        r_bcnt;
    logic                  r_issued;
    logic [31:0]           r_res_x, r_res_y;
    logic                  r_res_p;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                  div_state;
    logic signed [DW-1:0]  ex, ey, eu, ev;
    logic signed [VW-1:0]  vu_c, vv_c;
    logic signed [GW-1:0]  sat_s, hue_s, mul_a;
    logic signed [VW-1:0]  mul_b;
    logic signed [AW-1:0]  sum_c;
    logic signed [AW-1:0]  sum_sh;
    logic signed [UW:0]    mid_u, mid_v;
    logic                  x_fit, y_fit, pt_ok;
    logic [31:0]           clamp_x, clamp_y;

    pcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // shared arithmetic around the divider
    always_comb begin
        ex    = DW'(r_px);
        ey    = DW'(r_py);
        if (r_state == S_WU || r_state == S_WV) begin
            ex = DW'(r_wx);
            ey = DW'(r_wy);
        end
        eu    = DW'(r_cu);
        ev    = DW'(r_cv);
        vu_c  = VW'(r_pu) - VW'(r_wu);
        vv_c  = VW'(r_pv) - VW'(r_wv);
        sat_s = $signed({1'b0, r_sat});
        hue_s = $signed({1'b0, r_hue}) - GAIN_ONE;
        unique case (r_mcnt[1:0])
            2'd0:    begin mul_a = sat_s; mul_b = r_vu; end
            2'd1:    begin mul_a = hue_s; mul_b = r_vv; end
            2'd2:    begin mul_a = sat_s; mul_b = r_vv; end
            default: begin mul_a = hue_s; mul_b = r_vu; end
        endcase
        sum_c  = (r_mcnt == 3'd4) ? (r_acc - AW'(r_prod)) : (r_acc + AW'(r_prod));
        sum_sh = sum_c >>> 16;
        mid_u  = ($signed({r_lo_u[UW-1], r_lo_u}) + $signed({r_hi_u[UW-1], r_hi_u})) >>> 1;
        mid_v  = ($signed({r_lo_v[UW-1], r_lo_v}) + $signed({r_hi_v[UW-1], r_hi_v})) >>> 1;
        // xy must fit the 32-bit field
        x_fit  = (&r_x[QW-1:31]) | ~(|r_x[QW-1:31]);
        y_fit  = (&r_y[QW-1:31]) | ~(|r_y[QW-1:31]);
        pt_ok  = !r_zero && x_fit && y_fit && (r_y > Y_MIN_Q);
        clamp_x = x_fit ? r_x[31:0] : (r_x[QW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
        clamp_y = y_fit ? r_y[31:0] : (r_y[QW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_WU;
            S_WU:   if (div_rsp.done) n_state = S_WV;
            S_WV:   if (div_rsp.done) n_state = S_PU;
            S_PU:   if (div_rsp.done) n_state = S_PV;
            S_PV:   if (div_rsp.done) n_state = S_VEC;
            S_VEC:  n_state = (vu_c == '0 && vv_c == '0) ? S_OUT : S_MUL;
            S_MUL:  if (r_mcnt == 3'd4) n_state = S_HX;
            S_HX:   if (div_rsp.done) n_state = S_HY;
            S_HY:   if (div_rsp.done) n_state = S_HCHK;
            S_HCHK: n_state = pt_ok ? S_OUT : S_BMID;
            S_BMID: n_state = S_BX;
            S_BX:   if (div_rsp.done) n_state = S_BY;
            S_BY:   if (div_rsp.done) n_state = S_BCHK;
            S_BCHK: n_state = (r_bcnt == BCW'(BISECT_STEPS - 1)) ? S_FX : S_BMID;
            S_FX:   if (div_rsp.done) n_state = S_FY;
            S_FY:   if (div_rsp.done) n_state = S_OUT;
            S_OUT:  if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready   = (r_state == S_IDLE);
        div_state = 1'b0;
        div_req.num = '0;
        div_req.den = (eu <<< 1) - (ev <<< 3) + FX_FOUR;
        unique case (r_state)
            S_WU, S_PU: begin
                div_state   = 1'b1;
                div_req.num = ex <<< 2;
                div_req.den = (ey <<< 3) + (ey <<< 2) - (ex <<< 1) + FX_THREE;
            end
            S_WV, S_PV: begin
                div_state   = 1'b1;
                div_req.num = (ey <<< 2) + (ey <<< 1);
                div_req.den = (ey <<< 3) + (ey <<< 2) - (ex <<< 1) + FX_THREE;
            end
            S_HX, S_BX, S_FX: begin
                div_state   = 1'b1;
                div_req.num = (eu <<< 1) + eu;
            end
            S_HY, S_BY, S_FY: begin
                div_state   = 1'b1;
                div_req.num = ev <<< 1;
            end
            default: div_state = 1'b0;
        endcase
        div_req.start = div_state && !r_issued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_wx     <= 32'sd345401270;
            r_wy     <= 32'sd362570403;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WHITE_X: r_wx <= i_cfg_data;
                    CFG_WHITE_Y: r_wy <= i_cfg_data;
                endcase
            end

            if (div_req.start) begin
                r_issued <= 1'b1;
            end else if (div_rsp.done) begin
                r_issued <= 1'b0;
            end

            if (r_state == S_OUT && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_px  <= i_primary_x;
            r_py  <= i_primary_y;
            r_sat <= i_sat_gain;
            r_hue <= i_hue_gain;
        end
        if (div_rsp.done) begin
            unique case (r_state)
                S_WU:             r_wu <= div_rsp.quo;
                S_WV:             r_wv <= div_rsp.quo;
                S_PU:             r_pu <= div_rsp.quo;
                S_PV:             r_pv <= div_rsp.quo;
                S_HX, S_BX, S_FX: r_x  <= div_rsp.quo;
                S_HY, S_BY, S_FY: begin
                    r_y    <= div_rsp.quo;
                    r_zero <= div_rsp.zero;
                end
                default: ;
            endcase
        end
        unique case (r_state)
            S_VEC: begin
                r_vu    <= vu_c;
                r_vv    <= vv_c;
                r_mcnt  <= '0;
                r_res_x <= r_px;
                r_res_y <= r_py;
                r_res_p <= 1'b0;
            end
            S_MUL: begin
                r_mcnt <= r_mcnt + 3'd1;
                if (r_mcnt != 3'd4) begin
                    r_prod <= mul_a * mul_b;
                end
                // target = white + (sat*V + (hue-1)*perp(V)) / 2^16
                unique case (r_mcnt)
                    3'd1, 3'd3: r_acc <= AW'(r_prod);
                    3'd2: r_cu <= UW'(r_wu) + UW'(sum_sh);
                    3'd4: r_cv <= UW'(r_wv) + UW'(sum_sh);
                    default: ;
                endcase
            end
            S_HCHK: begin
                r_res_x <= r_x[31:0];
                r_res_y <= r_y[31:0];
                r_res_p <= 1'b0;
                r_lo_u  <= UW'(r_wu);
                r_lo_v  <= UW'(r_wv);
                r_hi_u  <= r_cu;
                r_hi_v  <= r_cv;
                r_bcnt  <= '0;
            end
            S_BMID: begin
                r_cu <= mid_u[UW-1:0];
                r_cv <= mid_v[UW-1:0];
            end
            S_BCHK: begin
                r_bcnt <= r_bcnt + BCW'(1);
                if (pt_ok) begin
                    r_lo_u <= r_cu;
                    r_lo_v <= r_cv;
                    r_cu   <= r_cu;
                    r_cv   <= r_cv;
                end else begin
                    r_hi_u <= r_cu;
                    r_hi_v <= r_cv;
                    r_cu   <= r_lo_u;
                    r_cv   <= r_lo_v;
                end
            end
            S_OUT: begin
                if (!o_valid || i_ready) begin
                    // a pulled-in result is the clamped last valid point
                    o_moved_x   <= r_res_p ? clamp_x : r_res_x;
                    o_moved_y   <= r_res_p ? clamp_y : r_res_y;
                    o_pulled_in <= r_res_p;
                end
            end
            default: ;
        endcase
        // final conversion of the last valid point
        if (r_state == S_FY && div_rsp.done) begin
            r_res_p <= 1'b1;
        end
    end

endmodule

// File: rtl/core/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// port-level assertions for primary_chromaticity_shift, bound to the top
// ----------------------------------------------------------------------------
`include "primary_chromaticity_shift_assert.svh"

module pcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_moved_x,
    input logic [31:0] o_moved_y,
    input logic        o_pulled_in
);

    // a waiting result holds its payload
    `PCS_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_moved_x) && $stable(o_moved_y) && $stable(o_pulled_in), "result changed while stalled")

    // the block is busy right after taking a request
    `PCS_ASSERT(a_busy_after_req, i_valid && o_ready |=> !o_ready, "ready stayed high after a request")

    // no result is produced while a request has just been taken and none was pending
    `PCS_ASSERT(a_no_instant_result, i_valid && o_ready && !o_valid |=> !o_valid, "result appeared without work")

    // reset empties the output register
    `PCS_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind primary_chromaticity_shift pcs_checker u_pcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_moved_x   (o_moved_x),
    .o_moved_y   (o_moved_y),
    .o_pulled_in (o_pulled_in)
);
